// File: sv/dnr_pkg.sv
// shared constants and types of the directional nearest rectangle search
package dnr_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = 9;
   localparam int SLOT_W      = 8;
   localparam int LEN_W       = (ADDR_W + 1 > COUNT_W) ? ADDR_W + 1 : COUNT_W;

   localparam int COORD_W     = 16;
   localparam int SIZE_W      = 15;
   localparam int ENTRY_W     = 2 * COORD_W + 2 * SIZE_W;
   localparam int CENTRE_W    = COORD_W + 2;
   localparam int DELTA_W     = CENTRE_W + 1;
   localparam int MAG_W       = CENTRE_W;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int DIST_W      = SQ_W + 1;

   localparam int REQ_DATA_W  = 96;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 8;
   localparam int RSP_USER_W  = 1;

   typedef enum logic [1:0] {
      DIR_LEFT  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_UP    = 2'd2,
      DIR_DOWN  = 2'd3
   } dir_type;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

endpackage

// File: sv/dnr_ram.sv
// generic single write port ram with registered read
module dnr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/directional_nearest_rect_core.sv
// directional nearest rectangle search: rectangle table and scanning sequencer
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/req_tready tdata: rectangle and query fields, tuser: kind flags
//   rsp      out  rsp_tvalid/rsp_tready tdata: best slot, tuser: found
//
// a write item goes to the table as it is taken; a query that needs no scan passes through
// the done state to the result register. a scanning query walks the table one entry at a
// time through one shared squaring multiplier: it reads the selected entry first, then
// addresses, loads and checks each entry; a candidate is squared in x, then y, and compared.
// synchronous reset clears the sequencer and the result valid flag; the table is not cleared.
// the request side stays not ready while a query runs or its result waits for a free
// result register; writes are still taken while an earlier result waits.
module directional_nearest_rect_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // entry_index, rect_x, rect_y, rect_width, rect_height, entries_in_use,
   // selected_slot, direction, zero fill
   input  logic [dnr_pkg::REQ_DATA_W-1:0]      req_tdata,
   // action, has_selection
   input  logic [dnr_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // best_slot
   output logic [dnr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // found
   output logic [dnr_pkg::RSP_USER_W-1:0]      rsp_tuser
);

   localparam int ADDR_W   = dnr_pkg::ADDR_W;
   localparam int LEN_W    = dnr_pkg::LEN_W;
   localparam int CENTRE_W = dnr_pkg::CENTRE_W;
   localparam int DELTA_W  = dnr_pkg::DELTA_W;
   localparam int MAG_W    = dnr_pkg::MAG_W;
   localparam int SQ_W     = dnr_pkg::SQ_W;
   localparam int DIST_W   = dnr_pkg::DIST_W;
   localparam int ENTRY_W  = dnr_pkg::ENTRY_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEL_ADDR,
      ST_SEL_LOAD,
      ST_ADDR,
      ST_LOAD,
      ST_CHK,
      ST_SQX,
      ST_SQY,
      ST_ACC,
      ST_DONE
   } state_type;

   function automatic logic signed [CENTRE_W-1:0] centre2(
      input logic [dnr_pkg::COORD_W-1:0] pos,
      input logic [dnr_pkg::SIZE_W-1:0]  size
   );
      logic signed [CENTRE_W-1:0] twice;
      logic signed [CENTRE_W-1:0] ext;
      twice = $signed({pos[dnr_pkg::COORD_W-1], pos, 1'b0});
      ext   = $signed({3'b000, size});
      return twice + ext;
   endfunction

   // request fields
   logic                           req_action;
   logic                           req_has_sel;
   logic [dnr_pkg::SLOT_W-1:0]     req_entry;
   logic [dnr_pkg::COORD_W-1:0]    req_x;
   logic [dnr_pkg::COORD_W-1:0]    req_y;
   logic [dnr_pkg::SIZE_W-1:0]     req_w;
   logic [dnr_pkg::SIZE_W-1:0]     req_h;
   logic [dnr_pkg::COUNT_W-1:0]    req_count;
   logic [dnr_pkg::SLOT_W-1:0]     req_sel;
   dnr_pkg::dir_type               req_dir;

   assign req_entry   = req_tdata[7:0];
   assign req_x       = req_tdata[23:8];
   assign req_y       = req_tdata[39:24];
   assign req_w       = req_tdata[54:40];
   assign req_h       = req_tdata[69:55];
   assign req_count   = req_tdata[78:70];
   assign req_sel     = req_tdata[86:79];
   assign req_dir     = dnr_pkg::dir_type'(req_tdata[88:87]);
   assign req_action  = req_tuser[0];
   assign req_has_sel = req_tuser[1];

   state_type                  state_ff, state_in;
   logic [LEN_W-1:0]           idx_ff, idx_in;
   logic [LEN_W-1:0]           cnt_ff, cnt_in;
   logic [LEN_W-1:0]           sel_ff, sel_in;
   dnr_pkg::dir_type           dir_ff, dir_in;
   logic signed [CENTRE_W-1:0] fx_ff, fx_in;
   logic signed [CENTRE_W-1:0] fy_ff, fy_in;
   logic signed [DELTA_W-1:0]  dx_ff, dx_in;
   logic signed [DELTA_W-1:0]  dy_ff, dy_in;
   logic [MAG_W-1:0]           ax_ff, ax_in;
   logic [MAG_W-1:0]           ay_ff, ay_in;
   logic [SQ_W-1:0]            sqx_ff, sqx_in;
   logic [SQ_W-1:0]            sqy_ff, sqy_in;
   logic                       found_ff, found_in;
   logic [ADDR_W-1:0]          best_ff, best_in;
   logic [DIST_W-1:0]          lead_sq_ff, lead_sq_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [dnr_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // table port
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [ENTRY_W-1:0]         wr_data;
   logic [ADDR_W-1:0]          rd_addr;
   logic [ENTRY_W-1:0]         rd_data;

   logic                       req_fire;
   logic [LEN_W-1:0]           req_len;
   logic [LEN_W-1:0]           req_sel_len;
   logic [LEN_W-1:0]           idx_next;
   logic signed [CENTRE_W-1:0] rd_cx;
   logic signed [CENTRE_W-1:0] rd_cy;
   logic [MAG_W-1:0]           abs_dx;
   logic [MAG_W-1:0]           abs_dy;
   logic                       in_dir;
   logic [MAG_W-1:0]           mul_op;
   logic [SQ_W-1:0]            mul_res;
   logic [DIST_W-1:0]          sum_sq;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign req_len     = (LEN_W'(req_count) > LEN_W'(dnr_pkg::MAX_ENTRIES))
                      ? LEN_W'(dnr_pkg::MAX_ENTRIES) : LEN_W'(req_count);
   assign req_sel_len = LEN_W'(req_sel);

   assign wr_en   = req_fire && (req_action == dnr_pkg::ACTION_WRITE)
                 && (LEN_W'(req_entry) < LEN_W'(dnr_pkg::MAX_ENTRIES));
   assign wr_addr = ADDR_W'(req_entry);
   assign wr_data = {req_h, req_w, req_y, req_x};
   assign rd_addr = (state_ff == ST_SEL_ADDR) ? ADDR_W'(sel_ff) : idx_ff[ADDR_W-1:0];

   dnr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (dnr_pkg::MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_cx = centre2(rd_data[15:0], rd_data[46:32]);
   assign rd_cy = centre2(rd_data[31:16], rd_data[61:47]);

   assign abs_dx = dx_ff[DELTA_W-1] ? MAG_W'(-dx_ff) : MAG_W'(dx_ff);
   assign abs_dy = dy_ff[DELTA_W-1] ? MAG_W'(-dy_ff) : MAG_W'(dy_ff);

   always_comb begin
      case (dir_ff)
         dnr_pkg::DIR_LEFT:  in_dir = dx_ff[DELTA_W-1] && (abs_dx > abs_dy);
         dnr_pkg::DIR_RIGHT: in_dir = !dx_ff[DELTA_W-1] && (abs_dx > abs_dy);
         dnr_pkg::DIR_UP:    in_dir = dy_ff[DELTA_W-1] && (abs_dy > abs_dx);
         dnr_pkg::DIR_DOWN:  in_dir = !dy_ff[DELTA_W-1] && (abs_dy > abs_dx);
         default:            in_dir = 1'b0;
      endcase
   end

   // shared squaring unit
   assign mul_op  = (state_ff == ST_SQX) ? ax_ff : ay_ff;
   assign mul_res = mul_op * mul_op;

   assign sum_sq   = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
   assign idx_next = idx_ff + LEN_W'(1);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      dir_in       = dir_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      lead_sq_in   = lead_sq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_action == dnr_pkg::ACTION_QUERY)) begin
               cnt_in   = req_len;
               sel_in   = req_sel_len;
               dir_in   = req_dir;
               idx_in   = '0;
               found_in = 1'b0;
               best_in  = '0;
               if (req_len == '0) begin
                  state_in = ST_DONE;
               end else if (!req_has_sel) begin
                  found_in = 1'b1;
                  state_in = ST_DONE;
               end else if (req_sel_len >= req_len) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SEL_ADDR;
               end
            end
         end
         ST_SEL_ADDR: begin
            state_in = ST_SEL_LOAD;
         end
         ST_SEL_LOAD: begin
            fx_in    = rd_cx;
            fy_in    = rd_cy;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            if (idx_ff == sel_ff) begin
               idx_in   = idx_next;
               state_in = (idx_next == cnt_ff) ? ST_DONE : ST_ADDR;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            dx_in    = DELTA_W'(rd_cx) - DELTA_W'(fx_ff);
            dy_in    = DELTA_W'(rd_cy) - DELTA_W'(fy_ff);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            ax_in = abs_dx;
            ay_in = abs_dy;
            if (in_dir) begin
               state_in = ST_SQX;
            end else begin
               idx_in   = idx_next;
               state_in = (idx_next == cnt_ff) ? ST_DONE : ST_ADDR;
            end
         end
         ST_SQX: begin
            sqx_in   = mul_res;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sqy_in   = mul_res;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!found_ff || (sum_sq < lead_sq_ff)) begin
               found_in   = 1'b1;
               lead_sq_in = sum_sq;
               best_in    = idx_ff[ADDR_W-1:0];
            end
            idx_in   = idx_next;
            state_in = (idx_next == cnt_ff) ? ST_DONE : ST_ADDR;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_slot_in  = found_ff ? dnr_pkg::SLOT_W'(best_ff) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      sel_ff       <= sel_in;
      dir_ff       <= dir_in;
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      lead_sq_ff   <= lead_sq_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_slot_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

// File: bench/nearest_rect_checker.sv
`timescale 1ns / 100ps
// request layout and the checker that mirrors the rectangle table and checks every search result
package rect_req_pkg;

   import dnr_pkg::*;

   // req_tdata seen as fields, lowest bits last
   typedef struct packed {
      logic [6:0]         fill;
      dir_type            direction;
      logic [7:0]         selected_slot;
      logic [8:0]         entries_in_use;
      logic [14:0]        rect_height;
      logic [14:0]        rect_width;
      logic signed [15:0] rect_y;
      logic signed [15:0] rect_x;
      logic [7:0]         entry_index;
   } rect_req_t;

   typedef struct packed {
      logic       found;
      logic [7:0] slot;
   } nearest_t;

endpackage

module nearest_rect_checker
   import dnr_pkg::*;
   import rect_req_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   output int unsigned           mismatches,
   output int unsigned           outstanding
);

   logic signed [15:0] tab_x [MAX_ENTRIES];
   logic signed [15:0] tab_y [MAX_ENTRIES];
   logic [14:0]        tab_w [MAX_ENTRIES];
   logic [14:0]        tab_h [MAX_ENTRIES];

   nearest_t expected_hits [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         tab_x[i] = '0;
         tab_y[i] = '0;
         tab_w[i] = '0;
         tab_h[i] = '0;
      end
   end

   function automatic nearest_t find_nearest(input rect_req_t q, input logic has_sel);
      nearest_t res;
      int       n;
      longint   fx, fy, dx, dy, adx, ady, sum_sq, lead_sq;
      bit       toward;
      res     = '0;
      lead_sq = 0;
      n = (q.entries_in_use > MAX_ENTRIES) ? MAX_ENTRIES : int'(q.entries_in_use);
      if (n == 0) return res;
      if (!has_sel) begin
         res.found = 1'b1;
         return res;
      end
      if (q.selected_slot >= n) return res;
      fx = 2 * longint'(tab_x[q.selected_slot]) + longint'(tab_w[q.selected_slot]);
      fy = 2 * longint'(tab_y[q.selected_slot]) + longint'(tab_h[q.selected_slot]);
      for (int i = 0; i < n; i++) begin
         if (i == q.selected_slot) continue;
         dx  = 2 * longint'(tab_x[i]) + longint'(tab_w[i]) - fx;
         dy  = 2 * longint'(tab_y[i]) + longint'(tab_h[i]) - fy;
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         case (q.direction)
            DIR_LEFT:  toward = dx < 0 && adx > ady;
            DIR_RIGHT: toward = dx > 0 && adx > ady;
            DIR_UP:    toward = dy < 0 && ady > adx;
            default:   toward = dy > 0 && ady > adx;
         endcase
         if (!toward) continue;
         sum_sq = dx * dx + dy * dy;
         if (!res.found || sum_sq < lead_sq) begin
            res.found = 1'b1;
            res.slot  = 8'(i);
            lead_sq   = sum_sq;
         end
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $time, what);
   endtask

   always @(posedge clock) begin
      rect_req_t req;
      nearest_t  want;
      if (!reset) begin
         // results first so an item taken at this edge cannot meet its own result
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hits.size() == 0) begin
               flag_mismatch($sformatf("unexpected item found=%b slot=%0d",
                                       rsp_tuser[0], rsp_tdata));
            end else begin
               want = expected_hits.pop_front();
               if (rsp_tuser[0] !== want.found || rsp_tdata !== want.slot)
                  flag_mismatch($sformatf("expected found=%b slot=%0d, got found=%b slot=%0d",
                                          want.found, want.slot, rsp_tuser[0], rsp_tdata));
            end
         end
         if (req_tvalid && req_tready) begin
            req = req_tdata;
            if (req_tuser[0] == ACTION_WRITE) begin
               tab_x[req.entry_index] = req.rect_x;
               tab_y[req.entry_index] = req.rect_y;
               tab_w[req.entry_index] = req.rect_width;
               tab_h[req.entry_index] = req.rect_height;
            end else begin
               expected_hits.push_back(find_nearest(req, req_tuser[1]));
            end
         end
         outstanding = expected_hits.size();
      end
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// bench top: clock, reset, table writes and directional queries, bursty sender, stalling receiver
module tb;

   import dnr_pkg::*;
   import rect_req_pkg::*;

   localparam int     DRAIN_CYCLES = 2000;
   localparam longint CYCLE_LIMIT  = 10_000_000;
   localparam int     RANDOM_ITEMS = 1100;

   typedef struct {
      rect_req_t  data;
      logic [1:0] user;
   } bus_item_t;

   typedef enum {RX_OPEN, RX_COIN, RX_CHOKED} rx_mode_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   int unsigned mismatches;
   int unsigned outstanding;
   longint      cycle_count = 0;

   bus_item_t   rect_items [$];
   int unsigned head       = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   rx_mode_t    rx_mode    = RX_OPEN;
   int unsigned mode_left  = 0;

   always #5 clock = ~clock;

   directional_nearest_rect_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   nearest_rect_checker check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   function automatic logic [15:0] pick_coord(input bit wide);
      case ($urandom_range(0, 19))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         default: return wide ? 16'($urandom) : 16'($urandom_range(0, 12) - 6);
      endcase
   endfunction

   function automatic logic [14:0] pick_size(input bit wide);
      case ($urandom_range(0, 19))
         0:       return 15'h7fff;
         1:       return 15'h0;
         default: return wide ? 15'($urandom) : 15'($urandom_range(0, 3));
      endcase
   endfunction

   // query-only fields carry noise on writes
   task automatic push_write(input logic [7:0] slot, input logic [15:0] x, input logic [15:0] y,
                             input logic [14:0] w, input logic [14:0] h);
      bus_item_t item;
      item.data             = rect_req_t'({$urandom, $urandom, $urandom});
      item.data.fill        = '0;
      item.data.entry_index = slot;
      item.data.rect_x      = x;
      item.data.rect_y      = y;
      item.data.rect_width  = w;
      item.data.rect_height = h;
      item.user             = {1'($urandom_range(0, 1)), ACTION_WRITE};
      rect_items.push_back(item);
   endtask

   // write-only fields carry noise on queries
   task automatic push_query(input logic [8:0] n, input logic has_sel, input logic [7:0] sel,
                             input dir_type dir);
      bus_item_t item;
      item.data                = rect_req_t'({$urandom, $urandom, $urandom});
      item.data.fill           = '0;
      item.data.entries_in_use = n;
      item.data.selected_slot  = sel;
      item.data.direction      = dir;
      item.user                = {has_sel, ACTION_QUERY};
      rect_items.push_back(item);
   endtask

   task automatic push_random_write(input bit wide_scene, input logic [7:0] slot);
      bit wide;
      wide = wide_scene || $urandom_range(0, 4) == 0;
      push_write(slot, pick_coord(wide), pick_coord(wide), pick_size(wide), pick_size(wide));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0 || head == rect_items.size()) begin
            req_tvalid <= 1'b0;
            if (gap_left != 0) gap_left--;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= rect_items[head].data;
            req_tuser  <= rect_items[head].user;
            head++;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (mode_left == 0) begin
         rx_mode   = rx_mode_t'($urandom_range(0, 2));
         mode_left = $urandom_range(16, 160);
      end else begin
         mode_left--;
      end
      case (rx_mode)
         RX_OPEN: rsp_tready <= 1'b1;
         RX_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int unsigned r;
      logic [8:0]  n;
      logic        has_sel;
      logic [7:0]  sel;
      bit          wide_scene;

      // centre, four neighbors, a diagonal, a tie with the left one, extremes
      push_write(8'd0, 16'sd0, 16'sd0, 15'd0, 15'd0);
      push_write(8'd1, 16'sd10, 16'sd0, 15'd0, 15'd0);
      push_write(8'd2, -16'sd10, 16'sd0, 15'd0, 15'd0);
      push_write(8'd3, 16'sd0, -16'sd10, 15'd0, 15'd0);
      push_write(8'd4, 16'sd0, 16'sd10, 15'd0, 15'd0);
      push_write(8'd5, 16'sd10, 16'sd10, 15'd0, 15'd0);
      push_write(8'd6, -16'sd10, 16'sd0, 15'd0, 15'd0);
      push_write(8'd7, 16'h8000, 16'h7fff, 15'h7fff, 15'h7fff);
      push_write(8'd8, 16'h7fff, 16'h8000, 15'h7fff, 15'h0);
      push_write(8'd255, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff);
      push_query(9'd9, 1'b1, 8'd0, DIR_LEFT);
      push_query(9'd9, 1'b1, 8'd0, DIR_RIGHT);
      push_query(9'd9, 1'b1, 8'd0, DIR_UP);
      push_query(9'd9, 1'b1, 8'd0, DIR_DOWN);
      push_query(9'd0, 1'b1, 8'd0, DIR_RIGHT);
      push_query(9'd511, 1'b0, 8'd200, DIR_UP);
      push_query(9'd9, 1'b1, 8'd9, DIR_LEFT);
      push_query(9'd2, 1'b1, 8'd0, DIR_LEFT);
      push_query(9'd1, 1'b1, 8'd0, DIR_DOWN);
      push_query(9'd6, 1'b1, 8'd5, DIR_LEFT);
      push_query(9'd9, 1'b1, 8'd7, DIR_RIGHT);
      push_query(9'd9, 1'b1, 8'd8, DIR_DOWN);

      // whole table written before any random query reads it
      wide_scene = 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (i % 64 == 0) wide_scene = ($urandom_range(0, 2) == 0);
         push_random_write(wide_scene, 8'(i));
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) wide_scene = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 99) < 45) begin
            push_random_write(wide_scene, 8'($urandom_range(0, 255)));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 80)      n = 9'($urandom_range(1, 24));
            else if (r < 88) n = 9'($urandom_range(256, 511));
            else if (r < 96) n = 9'($urandom_range(25, 255));
            else             n = 9'd0;
            has_sel = ($urandom_range(0, 9) != 0);
            if (n != 0 && n <= 255 && $urandom_range(0, 19) == 0)
               sel = 8'($urandom_range(n, 255));
            else if (n == 0)
               sel = 8'($urandom_range(0, 255));
            else
               sel = 8'($urandom_range(0, ((n > 256) ? 256 : n) - 1));
            push_query(n, has_sel, sel, dir_type'($urandom_range(0, 3)));
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (head < rect_items.size() || req_tvalid);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
